FILE: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

   // Queue geometry
   localparam int DEPTH = 8;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OCC_W = 4;
   localparam int VAL_W = 32;

   // Operation codes
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic                    kind;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] removed_value;
      logic [OCC_W-1:0]        occupancy;
   } rsp_type;

   // Per-cell control from the queue controller
   typedef struct packed {
      logic ins;       // accepted insert into a non-full queue
      logic rem;       // accepted remove from a non-empty queue
      logic occupied;  // cell index below count
      logic tail;      // cell index equals count (first free slot)
   } cell_ctrl_type;

endpackage

FILE: rtl/core/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
   input  logic                            clock,
   input  spq_pkg::cell_ctrl_type          ctrl,
   input  logic signed [spq_pkg::VAL_W-1:0] value,
   input  logic                            left_take,
   input  logic signed [spq_pkg::VAL_W-1:0] left_entry,
   input  logic signed [spq_pkg::VAL_W-1:0] right_entry,
   output logic                            take,
   output logic signed [spq_pkg::VAL_W-1:0] entry
);
   import spq_pkg::*;

   logic signed [VAL_W-1:0] entry_ff;
   logic signed [VAL_W-1:0] entry_in;
   logic                    load;

   // This slot changes on insert when it holds a larger value or is the first free one
   assign take  = ctrl.tail || (ctrl.occupied && (entry_ff > value));
   assign entry = entry_ff;

   // Insert: shift up from the left neighbor, or land the new value
   // Remove: shift down from the right neighbor
   always_comb begin
      load     = 1'b0;
      entry_in = entry_ff;
      if (ctrl.ins && take) begin
         load     = 1'b1;
         entry_in = left_take ? left_entry : value;
      end else if (ctrl.rem) begin
         load     = 1'b1;
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry_in;
      end
   end

endmodule

FILE: rtl/core/sorted_priority_queue.sv
`timescale 1ns / 1ps

// Sorted priority queue of DEPTH signed 32-bit entries held in a row of
// compare-and-shift cells, smallest at the front. On every request
// transfer (insert or remove-smallest) all cells compare and shift in
// parallel in the cycle of the transfer, and the result appears in the
// output register on the next cycle. A new request is taken every cycle
// as long as the result side does not stall; req_stall is high only while
// a result is held and rsp_stall is high. Equal values leave in arrival
// order. An insert into a full queue returns overflow, a remove from an
// empty queue returns underflow; neither changes the contents. Every
// result carries the occupancy after the operation (low 4 bits of count).
module sorted_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    accept;
   logic                    full;
   logic                    empty;
   logic                    do_ins;
   logic                    do_rem;
   logic [CNT_W+OCC_W-1:0]  occ_wide;

   cell_ctrl_type           ctrl   [DEPTH];
   logic                    take   [DEPTH];
   logic signed [VAL_W-1:0] entry  [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_ins    = accept && (req_data.kind == KIND_INSERT) && !full;
   assign do_rem    = accept && (req_data.kind == KIND_REMOVE) && !empty;

   // Cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      logic                    left_take;
      logic signed [VAL_W-1:0] left_entry;
      logic signed [VAL_W-1:0] right_entry;

      assign ctrl[i].ins      = do_ins;
      assign ctrl[i].rem      = do_rem;
      assign ctrl[i].occupied = (IDX < count_ff);
      assign ctrl[i].tail     = (IDX == count_ff);

      if (i == 0) begin : g_first
         assign left_take  = 1'b0;
         assign left_entry = '0;
      end else begin : g_mid
         assign left_take  = take[i-1];
         assign left_entry = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = entry[i];
      end else begin : g_inner
         assign right_entry = entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl[i]),
         .value       (req_data.value),
         .left_take   (left_take),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .take        (take[i]),
         .entry       (entry[i])
      );
   end

   // Count update
   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Result formation
   assign occ_wide = {{OCC_W{1'b0}}, count_in};

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = ST_OK;
         rsp_in.removed_value = '0;
         rsp_in.occupancy     = occ_wide[OCC_W-1:0];
         if (req_data.kind == KIND_INSERT) begin
            if (full) begin
               rsp_in.status = ST_OVERFLOW;
            end
         end else begin
            if (empty) begin
               rsp_in.status = ST_UNDERFLOW;
            end else begin
               rsp_in.removed_value = entry[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/core/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Every request transfer yields a result on the next cycle
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("request transfer without a result");

   // A failed insert or remove returns a zero value
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |-> (rsp_data.removed_value == '0))
      else $error("failed operation returned a value");

   // Overflow only at full, underflow only at empty
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.status != ST_OVERFLOW) || (rsp_data.occupancy == FULL_OCC))
                 && ((rsp_data.status != ST_UNDERFLOW) || (rsp_data.occupancy == '0)))
      else $error("status does not match occupancy");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
